[design/lrm_pkg.sv]
package lrm_pkg;

    localparam int FRAME_W_BITS = 11;
    localparam int FRAME_H_BITS = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int ROW_W        = FRAME_H_BITS + 1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int WIN_N    = 9;
    localparam int MED_RANK = 4;

    localparam int LUMA_W  = 15;
    localparam int LUMA_KR = 30;
    localparam int LUMA_KG = 59;
    localparam int LUMA_KB = 11;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;
    localparam int OUT_CW    = 3;

    // red in the lowest bits, matching the stream data layout
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    typedef logic [LUMA_W-1:0] t_luma;

    typedef t_pix  [WIN_N-1:0] t_win;
    typedef t_luma [WIN_N-1:0] t_lwin;

    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_line;

    typedef struct packed {
        logic flush;
        logic emit;
        logic med;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic last;
        t_pix pix;
    } t_out;

    function automatic t_luma luma_of(input t_pix p);
        return LUMA_W'(p.red) * LUMA_W'(LUMA_KR)
             + LUMA_W'(p.green) * LUMA_W'(LUMA_KG)
             + LUMA_W'(p.blue) * LUMA_W'(LUMA_KB);
    endfunction

endpackage

[design/lrm_median.sv]
module lrm_median (
    input  lrm_pkg::t_win  i_win,
    input  lrm_pkg::t_lwin i_luma,
    output lrm_pkg::t_pix  o_pix
);
    import lrm_pkg::*;

    logic [WIN_N-1:0] sel;
    logic [23:0]      acc;

    // rank each place: lower luma, or equal luma earlier in raster order, counts below
    always_comb begin
        logic [3:0] cnt;
        sel = '0;
        for (int i = 0; i < WIN_N; i++) begin
            cnt = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j != i && (i_luma[j] < i_luma[i] ||
                              (i_luma[j] == i_luma[i] && j < i))) begin
                    cnt = cnt + 4'd1;
                end
            end
            sel[i] = (cnt == 4'(MED_RANK));
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < WIN_N; i++) begin
            acc = acc | (sel[i] ? i_win[i] : 24'd0);
        end
    end

    assign o_pix = acc;

endmodule

[design/luma_ranked_median_3x3.sv]
// 3x3 vector median filter on RGB pixels in raster order. Each interior pixel is
// replaced by the window pixel of median luma (30R+59G+11B, ties to the earlier
// raster place); border pixels pass unchanged. One pixel or flush item is taken
// every clock while the output queue has room; a result passes the line store read
// register, the window registers and the combinational ranking before the queue.
// Both line rows sit in one single-port-per-side memory of MAX_WIDTH entries,
// read and written once per item, with forwarding for narrow frames. Output
// lags input by one row plus one pixel, so after the last pixel the source sends
// frame width plus one flush items to drain the tail; the final result carries
// tlast. A four-entry output queue keeps input flowing while results wait.
// Writing frame_width or frame_height restarts the frame. No clearing pass
// follows reset: unwritten line entries never reach a result.
module luma_ranked_median_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]                    s_axis_tuser,   // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // red_out, green_out, blue_out
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lrm_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CXW = ((AW > FRAME_W_BITS) ? AW : FRAME_W_BITS) + 1;
    localparam logic [FRAME_W_BITS-1:0] W_CAP =
        (MAX_WIDTH > 2047) ? {FRAME_W_BITS{1'b1}} : FRAME_W_BITS'(MAX_WIDTH);

    // configuration
    logic [FRAME_W_BITS-1:0] r_frame_width;
    logic [FRAME_H_BITS-1:0] r_frame_height;
    logic [FRAME_W_BITS-1:0] eff_w;
    logic [FRAME_H_BITS-1:0] eff_h;

    // position counters
    logic [AW-1:0]    r_in_column, n_in_column;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [AW-1:0]    col_c;
    logic [ROW_W-1:0] h_ext;
    logic             row_ge_h;
    logic             is_flush, take, act, col_wrap;
    t_ctl             ctl0;

    // line store
    t_line r_line_mem [MAX_WIDTH];
    t_line r_mem_q;
    t_line r_fwd_data;
    logic  r_fwd;
    t_line line_rd;
    t_line mem_wdata;
    logic  mem_we;

    // pipeline
    logic          r_s1_valid;
    t_ctl          r_s1_ctl;
    t_pix          r_s1_pix;
    logic [AW-1:0] r_s1_addr;
    logic          r_s2_valid;
    t_ctl          r_s2_ctl;
    t_win          r_win;
    t_lwin         r_lwin;
    t_pix          bottom_pix;
    t_pix          med_pix;
    t_pix          res_pix;

    // output queue
    t_out              r_fifo [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [OUT_CW-1:0] r_fifo_cnt;
    logic [OUT_CW-1:0] occ;
    logic              push, pop;
    t_out              head;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = FRAME_W_BITS'(1);
        end else if (r_frame_width > W_CAP) begin
            eff_w = W_CAP;
        end else begin
            eff_w = r_frame_width;
        end
        eff_h = (r_frame_height == '0) ? FRAME_H_BITS'(1) : r_frame_height;
    end

    assign h_ext    = ROW_W'(eff_h);
    assign row_ge_h = r_in_row >= h_ext;
    assign col_c    = (CXW'(r_in_column) >= CXW'(eff_w)) ? '0 : r_in_column;
    assign col_wrap = (CXW'(col_c) + CXW'(1)) >= CXW'(eff_w);
    assign is_flush = (s_axis_tuser[0] == CMD_FLUSH);
    assign take     = s_axis_tvalid && s_axis_tready;
    // pixels past the frame and flushes before its end are dropped
    assign act      = take && (is_flush ? row_ge_h : !row_ge_h);

    always_comb begin
        ctl0.flush = is_flush;
        ctl0.emit  = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && col_c != '0);
        ctl0.med   = (col_c >= AW'(2)) && (r_in_row >= ROW_W'(2)) && !row_ge_h;
        // the last result always falls on the first column two rows past the frame
        ctl0.last  = (r_in_row == h_ext + ROW_W'(1));
    end

    always_comb begin
        n_in_column = r_in_column;
        n_in_row    = r_in_row;
        if (act) begin
            if (ctl0.last) begin
                n_in_column = '0;
                n_in_row    = '0;
            end else if (col_wrap) begin
                n_in_column = '0;
                n_in_row    = r_in_row + ROW_W'(1);
            end else begin
                n_in_column = col_c + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_W_BITS'(640);
            r_frame_height <= FRAME_H_BITS'(480);
            r_in_column    <= '0;
            r_in_row       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_W_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_H_BITS-1:0];
                default: ;
            endcase
            r_in_column <= '0;
            r_in_row    <= '0;
        end else begin
            r_in_column <= n_in_column;
            r_in_row    <= n_in_row;
        end
    end

    // read-modify-write of the line store: read at transfer, written back in the next cycle
    assign line_rd          = r_fwd ? r_fwd_data : r_mem_q;
    assign mem_we           = r_s1_valid && !r_s1_ctl.flush;
    assign mem_wdata.upper  = line_rd.middle;
    assign mem_wdata.middle = r_s1_pix;
    assign bottom_pix       = r_s1_ctl.flush ? '0 : r_s1_pix;

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_line_mem[col_c];
        if (mem_we) begin
            r_line_mem[r_s1_addr] <= mem_wdata;
        end
    end

    // same entry written back while read again (single-column frames)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= mem_we && (r_s1_addr == col_c);
        end
        r_fwd_data <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= act;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_ctl  <= ctl0;
        r_s1_pix  <= s_axis_tdata;
        r_s1_addr <= col_c;
        r_s2_ctl  <= r_s1_ctl;
    end

    // window rows: upper, middle, bottom; oldest column first
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win[0]  <= r_win[1];
            r_win[1]  <= r_win[2];
            r_win[2]  <= line_rd.upper;
            r_win[3]  <= r_win[4];
            r_win[4]  <= r_win[5];
            r_win[5]  <= line_rd.middle;
            r_win[6]  <= r_win[7];
            r_win[7]  <= r_win[8];
            r_win[8]  <= bottom_pix;
            r_lwin[0] <= r_lwin[1];
            r_lwin[1] <= r_lwin[2];
            r_lwin[2] <= luma_of(line_rd.upper);
            r_lwin[3] <= r_lwin[4];
            r_lwin[4] <= r_lwin[5];
            r_lwin[5] <= luma_of(line_rd.middle);
            r_lwin[6] <= r_lwin[7];
            r_lwin[7] <= r_lwin[8];
            r_lwin[8] <= luma_of(bottom_pix);
        end
    end

    lrm_median u_median (
        .i_win  (r_win),
        .i_luma (r_lwin),
        .o_pix  (med_pix)
    );

    assign res_pix = r_s2_ctl.med ? med_pix : r_win[4];

    // output queue, sized so every item in flight has a slot
    assign push = r_s2_valid && r_s2_ctl.emit;
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign occ  = r_fifo_cnt + OUT_CW'(r_s1_valid && r_s1_ctl.emit) + OUT_CW'(push);
    assign s_axis_tready = occ < OUT_CW'(OUT_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{last: r_s2_ctl.last, pix: res_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + OUT_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + OUT_CW'(push) - OUT_CW'(pop);
        end
    end

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = r_fifo_cnt != '0;
    assign m_axis_tdata  = head.pix;
    assign m_axis_tlast  = head.last;

endmodule
